/* hdl/fsc_pkg.sv */
`timescale 1ns / 1ps
// fsc_pkg: widths, the signature rule table and its byte lookup for the
// file signature classifier; depends on nothing

package fsc_pkg;

	localparam int unsigned TABLE_SIZE     = 64;
	localparam int unsigned RULE_COUNT_DEF = 66;
	localparam int unsigned RULE_W         = $clog2(TABLE_SIZE);
	localparam int unsigned DATA_W         = 8;
	localparam int unsigned CODE_W         = 6;
	localparam int unsigned IDX_W          = 7;
	localparam int unsigned POS_W          = 9;
	localparam int unsigned OFF_W          = 9;
	localparam int unsigned LEN_W          = 4;
	localparam int unsigned PAT_BYTES      = 14;
	localparam int unsigned PAT_W          = PAT_BYTES * DATA_W;
	localparam logic [POS_W-1:0]  POS_MAX  = '1;
	localparam logic [CODE_W-1:0] CODE_UNKNOWN = '0;

	// pattern is right aligned: first byte of the span sits highest
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [OFF_W-1:0]  off;
		logic [LEN_W-1:0]  len;
		logic [PAT_W-1:0]  pat;
	} sig_rule_t;

	localparam sig_rule_t SIG_TABLE [TABLE_SIZE] = '{
		'{6'd1,  9'd28,  4'd8,  112'h4F70757348656164},
		'{6'd2,  9'd0,   4'd14, 112'h060E2B34020501010D0102010102},
		'{6'd3,  9'd0,   4'd11, 112'h233F52414449414E43450A},
		'{6'd4,  9'd0,   4'd11, 112'h0000001C667479704D3456},
		'{6'd5,  9'd0,   4'd10, 112'h3026B2758E66CF11A6D9},
		'{6'd6,  9'd0,   4'd8,  112'h0000001466747970},
		'{6'd7,  9'd0,   4'd8,  112'hD0CF11E0A1B11AE1},
		'{6'd8,  9'd0,   4'd7,  112'h213C617263683E},
		'{6'd3,  9'd0,   4'd7,  112'h233F524742450A},
		'{6'd9,  9'd4,   4'd7,  112'h667479704D3441},
		'{6'd10, 9'd0,   4'd6,  112'h377ABCAF271C},
		'{6'd11, 9'd0,   4'd6,  112'hFD377A585A00},
		'{6'd12, 9'd0,   4'd5,  112'h2321414D52},
		'{6'd13, 9'd0,   4'd5,  112'h7B5C727466},
		'{6'd14, 9'd257, 4'd5,  112'h7573746172},
		'{6'd15, 9'd0,   4'd5,  112'h0001000000},
		'{6'd16, 9'd0,   4'd4,  112'h49536328},
		'{6'd16, 9'd0,   4'd4,  112'h4D534346},
		'{6'd17, 9'd0,   4'd4,  112'h43723234},
		'{6'd18, 9'd0,   4'd4,  112'h762F3101},
		'{6'd19, 9'd0,   4'd4,  112'h664C6143},
		'{6'd20, 9'd0,   4'd4,  112'h464C4946},
		'{6'd21, 9'd0,   4'd4,  112'h464C5601},
		'{6'd22, 9'd0,   4'd4,  112'h00000100},
		'{6'd23, 9'd0,   4'd4,  112'h4C5A4950},
		'{6'd9,  9'd0,   4'd4,  112'h4D344120},
		'{6'd24, 9'd0,   4'd4,  112'h4D546864},
		'{6'd25, 9'd0,   4'd4,  112'h1A45DFA3},
		'{6'd26, 9'd0,   4'd4,  112'h33677035},
		'{6'd26, 9'd4,   4'd4,  112'h66747970},
		'{6'd27, 9'd0,   4'd4,  112'h00000162},
		'{6'd28, 9'd0,   4'd4,  112'h4F676753},
		'{6'd29, 9'd0,   4'd4,  112'h4F54544F},
		'{6'd30, 9'd0,   4'd4,  112'h25504446},
		'{6'd31, 9'd0,   4'd4,  112'h89504E47},
		'{6'd32, 9'd0,   4'd4,  112'h38425053},
		'{6'd33, 9'd0,   4'd4,  112'h52617221},
		'{6'd34, 9'd0,   4'd4,  112'hEDABEEDB},
		'{6'd35, 9'd0,   4'd4,  112'h53514C69},
		'{6'd36, 9'd0,   4'd4,  112'h3C737667},
		'{6'd37, 9'd0,   4'd4,  112'h49492A00},
		'{6'd37, 9'd0,   4'd4,  112'h4D4D002A},
		'{6'd38, 9'd8,   4'd4,  112'h57415645},
		'{6'd39, 9'd8,   4'd4,  112'h57454250},
		'{6'd40, 9'd0,   4'd4,  112'h774F4646},
		'{6'd41, 9'd0,   4'd4,  112'h774F4632},
		'{6'd42, 9'd8,   4'd3,  112'h415649},
		'{6'd43, 9'd0,   4'd3,  112'h425A68},
		'{6'd44, 9'd0,   4'd3,  112'h474946},
		'{6'd45, 9'd0,   4'd3,  112'h1F8B08},
		'{6'd46, 9'd0,   4'd3,  112'hFFD8FF},
		'{6'd47, 9'd0,   4'd3,  112'h4949BC},
		'{6'd48, 9'd0,   4'd3,  112'h494433},
		'{6'd49, 9'd0,   4'd2,  112'h424D},
		'{6'd50, 9'd0,   4'd2,  112'h7801},
		'{6'd51, 9'd0,   4'd2,  112'h4D5A},
		'{6'd52, 9'd0,   4'd2,  112'h2521},
		'{6'd53, 9'd1,   4'd2,  112'h5753},
		'{6'd54, 9'd0,   4'd2,  112'h1F9D},
		'{6'd54, 9'd0,   4'd2,  112'h1FA0},
		'{6'd55, 9'd0,   4'd2,  112'h504B},
		'{6'd56, 9'd0,   4'd1,  112'h7B},
		'{6'd56, 9'd0,   4'd1,  112'h5B},
		'{6'd57, 9'd0,   4'd1,  112'h3C}
	};

	// byte k of a rule's span (k below len)
	function automatic logic [DATA_W-1:0] sig_byte(sig_rule_t r, logic [LEN_W-1:0] k);
		logic [LEN_W-1:0] sh;
		logic [PAT_W-1:0] shifted;
		sh      = r.len - 4'd1 - k;
		shifted = r.pat >> {sh, 3'b000};
		return shifted[DATA_W-1:0];
	endfunction

endpackage

/* hdl/fsc_in_if.sv */
`timescale 1ns / 1ps
// fsc_in_if: byte stream channel into the classifier
// depends on fsc_pkg

interface fsc_in_if import fsc_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hdl/fsc_out_if.sv */
`timescale 1ns / 1ps
// fsc_out_if: result channel out of the classifier
// depends on fsc_pkg

interface fsc_out_if import fsc_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] type_code;
	logic [IDX_W-1:0]  rule_index;

	modport source (output valid, output type_code, output rule_index, input ready);
	modport sink (input valid, input type_code, input rule_index, output ready);
endinterface

/* hdl/file_signature_classifier.sv */
`timescale 1ns / 1ps
// file_signature_classifier: streaming file type detection by magic bytes
// depends on fsc_pkg, fsc_in_if, fsc_out_if
//
//   channel  | dir | payload                      | notes
//   ---------+-----+------------------------------+-------------------------------
//   data     | in  | data_byte[7:0], last_byte    | one file byte per transfer
//   result   | out | type_code[5:0], rule_index[6:0] | one transfer per last_byte
//
// cycles: one byte per cycle unless a last byte stalls; a byte sits in the input
//   register while its compare against all rules runs in parallel, and the
//   result register loads when the stage moves on a last byte (result.valid is
//   driven from the result register)
// reset: arst_n clears the handshake state, byte position and rearms all rules
// stalls: only a last byte waiting on a full, unread result register holds
//   data.ready low; ordinary bytes keep flowing while a result waits

module file_signature_classifier import fsc_pkg::*; #(
	parameter int unsigned RULE_COUNT = RULE_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fsc_in_if.sink    data,
	fsc_out_if.source result
);

	// rules beyond the table never match; fewer rules trims the table
	localparam int unsigned ACTIVE_RULES = (RULE_COUNT < TABLE_SIZE) ? RULE_COUNT : TABLE_SIZE;
	localparam logic [IDX_W-1:0] NO_MATCH_IDX = IDX_W'(RULE_COUNT);

	// input register
	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              last_s1;

	// per-file state
	logic [POS_W-1:0]      pos_q;
	logic [TABLE_SIZE-1:0] alive_q;

	// result register
	logic              res_valid_q;
	logic [CODE_W-1:0] res_code_q;
	logic [IDX_W-1:0]  res_idx_q;

	logic                  advance;
	logic [TABLE_SIZE-1:0] alive_nxt;
	logic [TABLE_SIZE-1:0] fits;
	logic                  found;
	logic [RULE_W-1:0]     win;
	logic [POS_W:0]        length;

	// the stage moves unless a last byte finds the result register occupied and unread
	assign advance    = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign data.ready = !valid_s1 || !last_s1 || !res_valid_q || result.ready;

	assign length = {1'b0, pos_q} + 10'd1;

	// per-rule compare of the current byte, all rules in parallel
	always_comb begin
		logic [POS_W:0]  span_end;
		logic [POS_W:0]  rel;
		logic            in_span;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			span_end = {1'b0, SIG_TABLE[i].off} + {6'd0, SIG_TABLE[i].len};
			rel      = {1'b0, pos_q} - {1'b0, SIG_TABLE[i].off};
			in_span  = (pos_q >= SIG_TABLE[i].off) && ({1'b0, pos_q} < span_end);
			alive_nxt[i] = alive_q[i] &&
				!(in_span && (sig_byte(SIG_TABLE[i], rel[LEN_W-1:0]) != byte_s1));
			fits[i] = (span_end <= length);
		end
	end

	// first surviving rule in table order wins
	always_comb begin
		found = 1'b0;
		win   = '0;
		for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
			if ((i < ACTIVE_RULES) && alive_nxt[i] && fits[i]) begin
				found = 1'b1;
				win   = RULE_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			byte_s1 <= data.data_byte;
			last_s1 <= data.last_byte;
		end
	end

	// position and match flags; a last byte rearms for the next file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			alive_q <= '1;
		end else if (advance) begin
			if (last_s1) begin
				pos_q   <= '0;
				alive_q <= '1;
			end else begin
				pos_q   <= (pos_q == POS_MAX) ? POS_MAX : pos_q + 9'd1;
				alive_q <= alive_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_code_q <= found ? SIG_TABLE[win].code : CODE_UNKNOWN;
			res_idx_q  <= found ? {1'b0, win} : NO_MATCH_IDX;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.type_code  = res_code_q;
	assign result.rule_index = res_idx_q;

endmodule

/* hdl/fsc_checker.sv */
`timescale 1ns / 1ps
// fsc_checker: port-level assertions for the file signature classifier
// depends on fsc_pkg; bound to file_signature_classifier at the end of this file

module fsc_checker import fsc_pkg::*; #(
	parameter int unsigned RULE_COUNT = RULE_COUNT_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CODE_W-1:0] out_code,
	input logic [IDX_W-1:0]  out_idx
);

	localparam logic [IDX_W-1:0] NO_MATCH_IDX = IDX_W'(RULE_COUNT);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_idx))
		else $error("result changed while stalled");

	// unknown type always reports the no-match index
	a_unknown_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_code == CODE_UNKNOWN) |-> out_idx == NO_MATCH_IDX)
		else $error("unknown type with a rule index");

	// a fresh result follows a last byte transfer through the input and result registers
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("result without a last byte");

	// input backpressure only comes from a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

endmodule

bind file_signature_classifier fsc_checker #(.RULE_COUNT(RULE_COUNT)) u_fsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (data.valid),
	.in_ready  (data.ready),
	.in_last   (data.last_byte),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_code  (result.type_code),
	.out_idx   (result.rule_index)
);
